// File: rtl/tie_pkg.sv
// Package for the toy instruction executor: opcodes, operand modes, fault codes,
// register indexes and the control/status structs between controller and datapath.
// No dependencies.
package tie_pkg;

    localparam int unsigned NUM_REGS = 11;
    localparam logic [3:0] REG_EAX = 4'd0;
    localparam logic [3:0] REG_IP  = 4'd6;
    localparam logic [3:0] REG_AF  = 4'd7;

    localparam logic [4:0] OP_MOV    = 5'd0;
    localparam logic [4:0] OP_ADD    = 5'd1;
    localparam logic [4:0] OP_SUB    = 5'd2;
    localparam logic [4:0] OP_MUL    = 5'd3;
    localparam logic [4:0] OP_DIV    = 5'd4;
    localparam logic [4:0] OP_MOD    = 5'd5;
    localparam logic [4:0] OP_AND    = 5'd6;
    localparam logic [4:0] OP_OR     = 5'd7;
    localparam logic [4:0] OP_EQ     = 5'd8;
    localparam logic [4:0] OP_NEQ    = 5'd9;
    localparam logic [4:0] OP_LESS   = 5'd10;
    localparam logic [4:0] OP_LEQ    = 5'd11;
    localparam logic [4:0] OP_JUMP   = 5'd12;
    localparam logic [4:0] OP_JZ     = 5'd13;
    localparam logic [4:0] OP_JNZ    = 5'd14;
    localparam logic [4:0] OP_PUSH   = 5'd15;
    localparam logic [4:0] OP_POP    = 5'd16;
    localparam logic [4:0] OP_CALL   = 5'd17;
    localparam logic [4:0] OP_INC    = 5'd18;
    localparam logic [4:0] OP_DEC    = 5'd19;
    localparam logic [4:0] OP_NEG    = 5'd20;
    localparam logic [4:0] OP_SET    = 5'd21;
    localparam logic [4:0] OP_UNSET  = 5'd22;
    localparam logic [4:0] OP_NOT    = 5'd23;
    localparam logic [4:0] OP_PRINT  = 5'd24;
    localparam logic [4:0] OP_RETURN = 5'd25;

    localparam logic [1:0] MODE_IMM  = 2'd0;
    localparam logic [1:0] MODE_MEM  = 2'd1;
    localparam logic [1:0] MODE_REG  = 2'd2;
    localparam logic [1:0] MODE_RIND = 2'd3;

    localparam logic [2:0] FAULT_NONE      = 3'd0;
    localparam logic [2:0] FAULT_IMM_WRITE = 3'd1;
    localparam logic [2:0] FAULT_DIVIDE    = 3'd2;
    localparam logic [2:0] FAULT_UNDERFLOW = 3'd3;
    localparam logic [2:0] FAULT_OVERFLOW  = 3'd4;
    localparam logic [2:0] FAULT_ADDRESS   = 3'd5;

    // operand kind after resolution
    localparam logic [1:0] KIND_IMM = 2'd0;
    localparam logic [1:0] KIND_MEM = 2'd1;
    localparam logic [1:0] KIND_REG = 2'd2;

    typedef struct packed {
        logic load;       // capture request fields
        logic res_a;      // resolve first operand, issue its memory read
        logic res_b;      // resolve second operand, issue its memory read
        logic fetch;      // capture operand values
        logic div_start;  // start divider
        logic commit;     // execute and write back
        logic clear;      // clearing-pass write of one memory word
    } t_ctrl;

    typedef struct packed {
        logic need_div;   // instruction goes through the divider
        logic div_done;
        logic clear_last;
    } t_stat;

endpackage

// File: rtl/tie_if.sv
// Valid/ready channel interface carrying a payload of type T.
// Depends on nothing.
interface tie_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/tie_div.sv
// Radix-2 restoring signed divider, one quotient bit per cycle.
// Depends on nothing.
module tie_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quo,
    output logic [31:0] o_rem
);
    logic [31:0] r_q, n_q;
    logic [32:0] r_r, n_r;
    logic [31:0] r_d;
    logic        r_nneg, r_dneg;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [32:0] w_shift, w_sub;

    always_comb begin
        w_shift = {r_r[31:0], r_q[31]};
        w_sub   = w_shift - {1'b0, r_d};
        n_q     = {r_q[30:0], ~w_sub[32]};
        n_r     = w_sub[32] ? w_shift : w_sub;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
                r_q    <= i_num[31] ? (32'd0 - i_num) : i_num;
                r_d    <= i_den[31] ? (32'd0 - i_den) : i_den;
                r_r    <= '0;
                r_nneg <= i_num[31];
                r_dneg <= i_den[31];
            end else if (r_busy) begin
                r_q   <= n_q;
                r_r   <= n_r;
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = (r_nneg ^ r_dneg) ? (32'd0 - r_q) : r_q;
    assign o_rem  = r_nneg ? (32'd0 - r_r[31:0]) : r_r[31:0];
endmodule

// File: rtl/tie_ctrl.sv
// Controller state machine: sequences clear pass, operand resolution, fetch,
// divide and commit for one request at a time. Depends on tie_pkg.
module tie_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  tie_pkg::t_stat i_stat,
    output tie_pkg::t_ctrl o_ctrl
);
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RESA  = 3'd2;
    localparam logic [2:0] S_RESB  = 3'd3;
    localparam logic [2:0] S_FETCH = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_EXEC  = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_accept;

    // a new request enters once the previous result has left or is leaving
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_ctrl      = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_ctrl.clear = 1'b1;
                if (i_stat.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    o_ctrl.load = 1'b1;
                    n_state = S_RESA;
                end
            end
            S_RESA: begin
                o_ctrl.res_a = 1'b1;
                n_state = S_RESB;
            end
            S_RESB: begin
                o_ctrl.res_b = 1'b1;
                n_state = S_FETCH;
            end
            S_FETCH: begin
                o_ctrl.fetch = 1'b1;
                n_state = S_EXEC;
                if (i_stat.need_div) begin
                    o_ctrl.div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) n_state = S_EXEC;
            end
            S_EXEC: begin
                o_ctrl.commit = 1'b1;
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

// File: rtl/tie_dp.sv
// Datapath: register file, data memory, call stack, operand resolution,
// ALU and result register. Depends on tie_pkg and tie_div.
module tie_dp #(
    parameter int MEM_WORDS   = 16384,
    parameter int STACK_DEPTH = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tie_pkg::t_ctrl i_ctrl,
    output tie_pkg::t_stat o_stat,
    input  logic [4:0]     i_opcode,
    input  logic [1:0]     i_first_mode,
    input  logic [31:0]    i_first_value,
    input  logic [1:0]     i_second_mode,
    input  logic [31:0]    i_second_value,
    output logic [31:0]    o_next_ip,
    output logic           o_print_valid,
    output logic [31:0]    o_print_value,
    output logic [2:0]     o_fault
);
    localparam int MAW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SPW = SAW + 1;

    logic [31:0] r_regs [tie_pkg::NUM_REGS];
    logic [31:0] r_mem  [MEM_WORDS];
    logic [31:0] r_stk  [STACK_DEPTH];
    logic [SPW-1:0] r_sp;
    logic [MAW-1:0] r_clr;

    logic [4:0]  r_op;
    logic [1:0]  r_mode_a, r_mode_b;
    logic [31:0] r_val_a, r_val_b;

    // resolved operands
    logic [1:0]     r_kind_a, r_kind_b;
    logic [MAW-1:0] r_maddr_a;
    logic [3:0]     r_ridx_a, r_ridx_b;
    logic [2:0]     r_rfault;
    logic [31:0]    r_mrd;      // registered memory read
    logic [31:0]    r_mrd_a;
    logic [31:0]    r_stk_rd;
    logic [31:0]    r_x, r_y;

    logic [31:0] r_next_ip, r_pval;
    logic        r_pvalid;
    logic [2:0]  r_fault;

    // resolution of one operand, mode/value chosen by phase
    logic [1:0]     w_mode, w_kind;
    logic [31:0]    w_val, w_rv;
    logic           w_bad;
    logic [MAW-1:0] w_maddr;
    logic           w_uses_a, w_uses_b;

    assign w_uses_a = (r_op <= tie_pkg::OP_PRINT);
    assign w_uses_b = (r_op <= tie_pkg::OP_LEQ);
    assign w_mode   = i_ctrl.res_b ? r_mode_b : r_mode_a;
    assign w_val    = i_ctrl.res_b ? r_val_b  : r_val_a;
    assign w_rv     = (w_val < 32'(tie_pkg::NUM_REGS)) ? r_regs[w_val[3:0]] : 32'd0;

    always_comb begin
        w_kind  = tie_pkg::KIND_IMM;
        w_bad   = 1'b0;
        w_maddr = w_val[MAW-1:0];
        case (w_mode)
            tie_pkg::MODE_IMM: w_kind = tie_pkg::KIND_IMM;
            tie_pkg::MODE_MEM: begin
                w_kind = tie_pkg::KIND_MEM;
                w_bad  = (w_val >= 32'(MEM_WORDS));
            end
            tie_pkg::MODE_REG: begin
                w_kind = tie_pkg::KIND_REG;
                w_bad  = (w_val >= 32'(tie_pkg::NUM_REGS));
            end
            default: begin
                w_kind  = tie_pkg::KIND_MEM;
                w_bad   = (w_val >= 32'(tie_pkg::NUM_REGS)) || (w_rv >= 32'(MEM_WORDS));
                w_maddr = w_rv[MAW-1:0];
            end
        endcase
    end

    // operand value read
    function automatic logic [31:0] f_opval(input logic [1:0] kind, input logic [31:0] mrd,
                                            input logic [31:0] rv, input logic [31:0] imm);
        logic [31:0] v;
        begin
            v = imm;
            if (kind == tie_pkg::KIND_MEM) v = mrd;
            else if (kind == tie_pkg::KIND_REG) v = rv;
            f_opval = v;
        end
    endfunction

    // divider
    logic        w_div_done;
    logic [31:0] w_quo, w_rem;
    logic        w_divop, w_divfault;
    assign w_divop    = (r_op == tie_pkg::OP_DIV) || (r_op == tie_pkg::OP_MOD);
    assign w_divfault = (r_y == 32'd0) || (r_x == 32'h8000_0000 && r_y == 32'hFFFF_FFFF);

    tie_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctrl.div_start),
        .i_num   (f_opval(r_kind_a, r_mrd_a, r_regs[r_ridx_a], r_val_a)),
        .i_den   (f_opval(r_kind_b, r_mrd, r_regs[r_ridx_b], r_val_b)),
        .o_done  (w_div_done),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    assign o_stat.need_div   = w_divop && (r_rfault == tie_pkg::FAULT_NONE);
    assign o_stat.div_done   = w_div_done;
    assign o_stat.clear_last = (r_clr == MAW'(MEM_WORDS - 1));

    // execute
    logic [31:0] w_prod;
    logic        w_writes;
    logic [2:0]  w_fault;
    logic        w_wr_dst, w_wr_eax, w_wr_af, w_jump, w_push, w_pop_sp;
    logic [31:0] w_dst_v, w_eax_v, w_af_v, w_jump_v, w_push_v;
    logic        w_sp_full, w_sp_empty;

    assign w_prod     = r_x * r_y;
    assign w_sp_full  = (r_sp >= SPW'(STACK_DEPTH));
    assign w_sp_empty = (r_sp == '0);
    assign w_writes   = (r_op == tie_pkg::OP_MOV) || (r_op == tie_pkg::OP_POP) ||
                        (r_op >= tie_pkg::OP_INC && r_op <= tie_pkg::OP_UNSET);

    always_comb begin
        w_fault  = r_rfault;
        w_wr_dst = 1'b0;
        w_wr_eax = 1'b0;
        w_wr_af  = 1'b0;
        w_jump   = 1'b0;
        w_push   = 1'b0;
        w_pop_sp = 1'b0;
        w_dst_v  = r_y;
        w_eax_v  = 32'd0;
        w_af_v   = 32'd0;
        w_jump_v = r_x;
        w_push_v = r_x;
        if (w_fault == tie_pkg::FAULT_NONE && w_writes && r_kind_a == tie_pkg::KIND_IMM)
            w_fault = tie_pkg::FAULT_IMM_WRITE;
        if (w_fault == tie_pkg::FAULT_NONE) begin
            case (r_op)
                tie_pkg::OP_MOV: w_wr_dst = 1'b1;
                tie_pkg::OP_ADD: begin w_wr_eax = 1'b1; w_eax_v = r_x + r_y; end
                tie_pkg::OP_SUB: begin w_wr_eax = 1'b1; w_eax_v = r_x - r_y; end
                tie_pkg::OP_MUL: begin w_wr_eax = 1'b1; w_eax_v = w_prod; end
                tie_pkg::OP_DIV, tie_pkg::OP_MOD: begin
                    if (w_divfault) w_fault = tie_pkg::FAULT_DIVIDE;
                    else begin
                        w_wr_eax = 1'b1;
                        w_eax_v  = (r_op == tie_pkg::OP_DIV) ? w_quo : w_rem;
                    end
                end
                tie_pkg::OP_AND: begin
                    w_wr_af = 1'b1; w_af_v = {31'd0, (r_x != 0) && (r_y != 0)};
                end
                tie_pkg::OP_OR: begin
                    w_wr_af = 1'b1; w_af_v = {31'd0, (r_x != 0) || (r_y != 0)};
                end
                tie_pkg::OP_EQ:  begin w_wr_af = 1'b1; w_af_v = {31'd0, r_x == r_y}; end
                tie_pkg::OP_NEQ: begin w_wr_af = 1'b1; w_af_v = {31'd0, r_x != r_y}; end
                tie_pkg::OP_LESS: begin
                    w_wr_af = 1'b1; w_af_v = {31'd0, $signed(r_x) < $signed(r_y)};
                end
                tie_pkg::OP_LEQ: begin
                    w_wr_af = 1'b1; w_af_v = {31'd0, $signed(r_x) <= $signed(r_y)};
                end
                tie_pkg::OP_JUMP: w_jump = 1'b1;
                tie_pkg::OP_JZ:   w_jump = (r_regs[tie_pkg::REG_AF] != 32'd0);
                tie_pkg::OP_JNZ:  w_jump = (r_regs[tie_pkg::REG_AF] == 32'd0);
                tie_pkg::OP_PUSH: begin
                    if (w_sp_full) w_fault = tie_pkg::FAULT_OVERFLOW;
                    else w_push = 1'b1;
                end
                tie_pkg::OP_POP: begin
                    if (w_sp_empty) w_fault = tie_pkg::FAULT_UNDERFLOW;
                    else begin w_pop_sp = 1'b1; w_wr_dst = 1'b1; w_dst_v = r_stk_rd; end
                end
                tie_pkg::OP_CALL: begin
                    if (w_sp_full) w_fault = tie_pkg::FAULT_OVERFLOW;
                    else begin
                        w_push = 1'b1; w_push_v = r_regs[tie_pkg::REG_IP]; w_jump = 1'b1;
                    end
                end
                tie_pkg::OP_INC:   begin w_wr_dst = 1'b1; w_dst_v = r_x + 32'd1; end
                tie_pkg::OP_DEC:   begin w_wr_dst = 1'b1; w_dst_v = r_x - 32'd1; end
                tie_pkg::OP_NEG:   begin w_wr_dst = 1'b1; w_dst_v = 32'd0 - r_x; end
                tie_pkg::OP_SET:   begin w_wr_dst = 1'b1; w_dst_v = 32'd1; end
                tie_pkg::OP_UNSET: begin w_wr_dst = 1'b1; w_dst_v = 32'd0; end
                tie_pkg::OP_NOT: begin w_wr_af = 1'b1; w_af_v = {31'd0, r_x == 32'd0}; end
                tie_pkg::OP_RETURN: begin
                    if (w_sp_empty) w_fault = tie_pkg::FAULT_UNDERFLOW;
                    else w_pop_sp = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // ip after any register writes of this instruction
    logic [31:0] w_ip_base;
    always_comb begin
        w_ip_base = r_regs[tie_pkg::REG_IP];
        if (w_wr_dst && r_kind_a == tie_pkg::KIND_REG && r_ridx_a == tie_pkg::REG_IP)
            w_ip_base = w_dst_v;
        if (r_op == tie_pkg::OP_RETURN && w_pop_sp) w_ip_base = r_stk_rd;
    end

    logic [SPW-1:0] w_sp_m1;
    assign w_sp_m1 = r_sp - SPW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp  <= '0;
            r_clr <= '0;
            for (int i = 0; i < tie_pkg::NUM_REGS; i++) r_regs[i] <= 32'd0;
        end else begin
            if (i_ctrl.clear) r_clr <= r_clr + MAW'(1);
            if (i_ctrl.commit) begin
                if (w_push) r_sp <= r_sp + SPW'(1);
                if (w_pop_sp) r_sp <= w_sp_m1;
                if (w_wr_eax) r_regs[tie_pkg::REG_EAX] <= w_eax_v;
                if (w_wr_af) r_regs[tie_pkg::REG_AF] <= w_af_v;
                // ip destination goes through the ip update below
                if (w_wr_dst && r_kind_a == tie_pkg::KIND_REG && r_ridx_a != tie_pkg::REG_IP)
                    r_regs[r_ridx_a] <= w_dst_v;
                r_regs[tie_pkg::REG_IP] <= w_jump ? w_jump_v : (w_ip_base + 32'd1);
            end
        end
    end

    // data memory: one write port, one registered read port
    logic [MAW-1:0] w_mem_ra;
    assign w_mem_ra = w_maddr;
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) r_mem[r_clr] <= 32'd0;
        else if (i_ctrl.commit && w_wr_dst && r_kind_a == tie_pkg::KIND_MEM)
            r_mem[r_maddr_a] <= w_dst_v;
        r_mrd <= r_mem[w_mem_ra];
    end

    // call stack: read top during resolution
    always_ff @(posedge i_clk) begin
        if (i_ctrl.commit && w_push) r_stk[r_sp[SAW-1:0]] <= w_push_v;
        r_stk_rd <= r_stk[w_sp_m1[SAW-1:0]];
    end

    // request capture, resolution and operand fetch
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_op     <= i_opcode;
            r_mode_a <= i_first_mode;
            r_val_a  <= i_first_value;
            r_mode_b <= i_second_mode;
            r_val_b  <= i_second_value;
        end
        if (i_ctrl.res_a) begin
            r_kind_a  <= w_kind;
            r_maddr_a <= w_maddr;
            r_ridx_a  <= w_val[3:0];
            r_rfault  <= (w_uses_a && w_bad) ? tie_pkg::FAULT_ADDRESS : tie_pkg::FAULT_NONE;
        end
        if (i_ctrl.res_b) begin
            r_mrd_a   <= r_mrd;
            r_kind_b  <= w_kind;
            r_ridx_b  <= w_val[3:0];
            if (r_rfault == tie_pkg::FAULT_NONE && w_uses_b && w_bad)
                r_rfault <= tie_pkg::FAULT_ADDRESS;
        end
        if (i_ctrl.fetch) begin
            r_x <= w_uses_a ? f_opval(r_kind_a, r_mrd_a, r_regs[r_ridx_a], r_val_a) : 32'd0;
            r_y <= w_uses_b ? f_opval(r_kind_b, r_mrd, r_regs[r_ridx_b], r_val_b) : 32'd0;
        end
        if (i_ctrl.commit) begin
            r_next_ip <= w_jump ? w_jump_v : (w_ip_base + 32'd1);
            r_fault   <= w_fault;
            r_pvalid  <= (w_fault == tie_pkg::FAULT_NONE) && (r_op == tie_pkg::OP_PRINT);
            r_pval    <= ((w_fault == tie_pkg::FAULT_NONE) && (r_op == tie_pkg::OP_PRINT))
                         ? r_x : 32'd0;
        end
    end

    assign o_next_ip     = r_next_ip;
    assign o_print_valid = r_pvalid;
    assign o_print_value = r_pval;
    assign o_fault       = r_fault;
endmodule

// File: rtl/toy_isa_instruction_executor.sv
// Toy instruction executor top level: controller, datapath and channel ports.
// Each accepted request steps through resolve-first, resolve-second, fetch, divide
// (div and mod only) and commit, one request at a time; the sequence is set by the
// operand resolve/fetch steps through the single data-memory read port.
// Reset: synchronous active low; then a clearing pass zeroes every data-memory
// word in turn before the first request is accepted.
module toy_isa_instruction_executor #(
    parameter int MEM_WORDS   = 16384,
    parameter int STACK_DEPTH = 256
) (
    input logic i_clk,
    input logic i_rst_n,
    tie_if.sink   i_req,
    tie_if.source o_rsp
);
    tie_pkg::t_ctrl w_ctrl;
    tie_pkg::t_stat w_stat;

    tie_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_ctrl      (w_ctrl)
    );

    tie_dp #(.MEM_WORDS(MEM_WORDS), .STACK_DEPTH(STACK_DEPTH)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_ctrl),
        .o_stat         (w_stat),
        .i_opcode       (i_req.payload.opcode),
        .i_first_mode   (i_req.payload.first_mode),
        .i_first_value  (i_req.payload.first_value),
        .i_second_mode  (i_req.payload.second_mode),
        .i_second_value (i_req.payload.second_value),
        .o_next_ip      (o_rsp.payload.next_ip),
        .o_print_valid  (o_rsp.payload.print_valid),
        .o_print_value  (o_rsp.payload.print_value),
        .o_fault        (o_rsp.payload.fault)
    );
endmodule

// File: rtl/tie_chk.sv
// Port-level checker for the instruction executor, bound to the top level.
// Depends on tie_pkg.
module tie_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_print_valid,
    input logic [31:0] i_print_value,
    input logic [2:0]  i_fault
);
    // one request at a time: no accept the cycle after another
    a_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !(i_in_valid && i_in_ready))
        else $error("back-to-back accept");

    a_fault_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_fault <= tie_pkg::FAULT_ADDRESS))
        else $error("fault code out of range");

    a_print_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_print_valid) |-> (i_print_value == 32'd0))
        else $error("print value not zero");

    a_print_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_print_valid) |-> (i_fault == tie_pkg::FAULT_NONE))
        else $error("print with fault");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped");
endmodule

bind toy_isa_instruction_executor tie_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_print_valid (o_rsp.payload.print_valid),
    .i_print_value (o_rsp.payload.print_value),
    .i_fault       (o_rsp.payload.fault)
);
